// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while the synchronous reset is low.
`define CRAD_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds while reset is applied.
`define CRAD_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/crad_pkg.sv =====
// Types, constants and helper functions of the controller report decoder.
package crad_pkg;

    typedef logic [7:0] t_byte;

    localparam int unsigned NumBytes = 8;
    localparam int unsigned NumAxes  = 6;

    // Axis slots of the held report.
    localparam int unsigned AxLeftX   = 0;
    localparam int unsigned AxLeftY   = 1;
    localparam int unsigned AxRightX  = 2;
    localparam int unsigned AxRightY  = 3;
    localparam int unsigned AxTrigL   = 4;
    localparam int unsigned AxTrigR   = 5;

    localparam t_byte StickCenter = 8'd127;
    localparam t_byte TrigRest    = 8'd0;
    localparam t_byte ByteMax     = 8'd255;
    localparam t_byte ByteMin     = 8'd0;

    localparam t_byte FailLimitReset = 8'd5;
    localparam t_byte GoodLimitReset = 8'd15;

    // Configuration register indexes.
    localparam logic CfgFailLimit = 1'b0;
    localparam logic CfgGoodLimit = 1'b1;

    // Stick scaling: (v + 80) * 255 / 160 equals (v + 80) * 51 / 32.
    localparam int          StickClamp      = 80;
    localparam logic [13:0] StickScaleMul   = 14'd51;
    localparam int unsigned StickScaleShift = 5;

    typedef struct packed {
        logic                       mode;
        t_byte                      fail_run;
        t_byte                      good_run;
        logic [3:0]                 held_dpad;
        logic [11:0]                buttons;
        t_byte [NumAxes-1:0]        axes;
    } t_state;

    typedef struct packed {
        logic                       read_complete;
        t_byte [NumBytes-1:0]       b;
    } t_item;

    typedef struct packed {
        t_byte fail_limit;
        t_byte good_limit;
    } t_cfg;

    function automatic t_byte [NumAxes-1:0] cleared_axes();
        t_byte [NumAxes-1:0] a;
        a           = '0;
        a[AxLeftX]  = StickCenter;
        a[AxLeftY]  = StickCenter;
        a[AxRightX] = StickCenter;
        a[AxRightY] = StickCenter;
        a[AxTrigL]  = TrigRest;
        a[AxTrigR]  = TrigRest;
        return a;
    endfunction

    // Clamps a two's complement stick reading to +-80 and maps it onto 0..255.
    function automatic t_byte scale_stick(t_byte raw);
        logic signed [8:0] v;
        logic [8:0]        offs;
        logic [13:0]       prod;
        v = 9'($signed(raw));
        if (v > 9'(StickClamp)) begin
            v = 9'(StickClamp);
        end else if (v < -9'(StickClamp)) begin
            v = -9'(StickClamp);
        end
        offs = 9'(v + 9'(StickClamp));
        prod = 14'(offs) * StickScaleMul;
        return t_byte'(prod >> StickScaleShift);
    endfunction

endpackage

// ===== hw/rtl/crad_decode.sv =====
// Next-state and report decode for one controller poll.
module crad_decode (
    input  crad_pkg::t_state i_state,
    input  crad_pkg::t_item  i_item,
    input  crad_pkg::t_cfg   i_cfg,
    output crad_pkg::t_state o_state,
    output logic             o_switched
);

    crad_pkg::t_byte b0;
    crad_pkg::t_byte b1;
    logic            cube;
    logic            mcu_valid;
    logic            sr_present;
    logic            good_read;
    crad_pkg::t_byte fail_inc;
    crad_pkg::t_byte good_inc;
    logic [3:0]      pad;
    logic [3:0]      dpad;
    logic [11:0]     mcu_btn;
    logic [11:0]     sr_btn;
    logic [15:0]     w;
    crad_pkg::t_byte [crad_pkg::NumAxes-1:0] mcu_axes;

    assign b0   = i_item.b[0];
    assign b1   = i_item.b[1];
    assign cube = b1[6];
    assign w    = {b0, b1};

    assign mcu_valid  = i_item.read_complete && b1[7] && !(cube && b1[0]);
    assign sr_present = i_item.read_complete && !i_item.b[2][0];
    assign good_read  = i_state.mode ? sr_present : mcu_valid;

    assign fail_inc = (i_state.fail_run == crad_pkg::ByteMax) ?
                      i_state.fail_run : i_state.fail_run + 8'd1;
    assign good_inc = (i_state.good_run == crad_pkg::ByteMax) ?
                      i_state.good_run : i_state.good_run + 8'd1;

    // The held d-pad only follows combinations that a real pad can produce.
    assign pad  = ~b0[3:0];
    assign dpad = (pad[1:0] != 2'b11 && pad[3:2] != 2'b11) ? pad : i_state.held_dpad;

    always_comb begin
        mcu_btn     = '0;
        mcu_btn[4]  = !b0[5];
        mcu_btn[7]  = !b0[4];
        mcu_btn[6]  = !b1[5];
        mcu_btn[5]  = !b1[4];
        mcu_btn[8]  = dpad[3];
        mcu_btn[9]  = dpad[2];
        mcu_btn[10] = dpad[1];
        mcu_btn[11] = dpad[0];
        mcu_axes    = crad_pkg::cleared_axes();
        if (cube) begin
            mcu_btn[0] = !b0[6];
            mcu_btn[1] = !b0[7];
            mcu_btn[2] = !b1[2];
            mcu_btn[3] = !b1[3];
            mcu_axes[crad_pkg::AxLeftX]  = i_item.b[2];
            mcu_axes[crad_pkg::AxLeftY]  = ~i_item.b[3];
            mcu_axes[crad_pkg::AxRightX] = i_item.b[4];
            mcu_axes[crad_pkg::AxRightY] = ~i_item.b[5];
            mcu_axes[crad_pkg::AxTrigL]  = i_item.b[6];
            mcu_axes[crad_pkg::AxTrigR]  = i_item.b[7];
        end else begin
            mcu_btn[0] = !b0[7];
            mcu_btn[1] = !b0[6];
            mcu_btn[2] = !b1[3];
            mcu_btn[3] = !b1[2];
            if (!b1[0]) begin
                mcu_axes[crad_pkg::AxRightX] = crad_pkg::ByteMax;
            end else if (!b1[1]) begin
                mcu_axes[crad_pkg::AxRightX] = crad_pkg::ByteMin;
            end
            mcu_axes[crad_pkg::AxLeftX] = crad_pkg::scale_stick(i_item.b[2]);
            mcu_axes[crad_pkg::AxLeftY] = crad_pkg::scale_stick(i_item.b[3]);
        end
    end

    // Shift-register word is active low; opposite directions cancel.
    always_comb begin
        sr_btn    = '0;
        sr_btn[0] = !w[13];
        sr_btn[1] = !w[3];
        sr_btn[2] = !w[12];
        sr_btn[3] = !w[2];
        sr_btn[4] = !w[11];
        sr_btn[5] = !w[0];
        sr_btn[6] = !w[1];
        sr_btn[7] = !w[10];
        if (w[9] || w[8]) begin
            sr_btn[8] = !w[9];
            sr_btn[9] = !w[8];
        end
        if (w[5] || w[4]) begin
            sr_btn[10] = !w[5];
            sr_btn[11] = !w[4];
        end
    end

    always_comb begin
        o_state    = i_state;
        o_switched = 1'b0;
        if (good_read) begin
            o_state.fail_run = '0;
            if (i_state.mode) begin
                o_state.buttons = sr_btn;
                o_state.axes    = crad_pkg::cleared_axes();
            end else begin
                o_state.good_run = good_inc;
                if (good_inc >= i_cfg.good_limit) begin
                    o_state.held_dpad = dpad;
                    o_state.buttons   = mcu_btn;
                    o_state.axes      = mcu_axes;
                end
            end
        end else begin
            if (!i_state.mode) begin
                o_state.good_run = '0;
            end
            o_state.fail_run = fail_inc;
            if (fail_inc >= i_cfg.fail_limit) begin
                o_state.fail_run = '0;
                o_state.mode     = !i_state.mode;
                o_state.buttons  = '0;
                o_state.axes     = crad_pkg::cleared_axes();
                o_switched       = 1'b1;
            end
        end
    end

endmodule

// ===== hw/rtl/controller_report_autodetect_decoder_core.sv =====
// Controller report decoder with protocol autodetection: one beat in carries a
// finished poll (completion flag in tuser, the eight raw report bytes in tdata,
// byte0 lowest) and one beat out carries the protocol mode for the next poll,
// a flag that this poll changed the mode, and the held report (buttons, four
// stick axes, two triggers). A poll is held in the input register and then
// decoded into the result register when that is empty or being drained; the
// mode, streak counters, held d-pad and report are updated in that same cycle,
// so the block takes one beat per cycle whenever the output is drained. The fail
// and good limits (configuration port index 0 and 1; 5 and 15 after reset) are
// written by the user only while no poll is in flight; the block does not enforce it.
module controller_report_autodetect_decoder_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_addr,
    input  logic [7:0]  i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // byte0 .. byte7, byte0 lowest
    input  logic        s_axis_tuser,   // read_complete
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // buttons, left_x, left_y, right_x, right_y,
                                        // trigger_left, trigger_right, zero pad
    output logic [1:0]  m_axis_tuser    // protocol_mode, protocol_switched
);

    logic              r_in_valid;
    crad_pkg::t_item   r_in_item;
    logic              r_out_valid;
    logic [63:0]       r_out_tdata;
    logic [1:0]        r_out_tuser;
    crad_pkg::t_state  r_state;
    crad_pkg::t_state  n_state;
    crad_pkg::t_cfg    r_cfg;
    logic              switched;
    logic              advance;

    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    crad_decode u_decode (
        .i_state    (r_state),
        .i_item     (r_in_item),
        .i_cfg      (r_cfg),
        .o_state    (n_state),
        .o_switched (switched)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid        <= 1'b0;
            r_out_valid       <= 1'b0;
            r_state           <= '0;
            r_cfg.fail_limit  <= crad_pkg::FailLimitReset;
            r_cfg.good_limit  <= crad_pkg::GoodLimitReset;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (advance) begin
                r_state     <= n_state;
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    crad_pkg::CfgFailLimit: r_cfg.fail_limit <= i_cfg_data;
                    crad_pkg::CfgGoodLimit: r_cfg.good_limit <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_item <= {s_axis_tuser, s_axis_tdata};
        end
        if (advance) begin
            r_out_tdata <= {4'b0000, n_state.axes, n_state.buttons};
            r_out_tuser <= {switched, n_state.mode};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_tdata;
    assign m_axis_tuser  = r_out_tuser;

endmodule

// ===== hw/rtl/crad_checker.sv =====
// Port-level checks of the controller report decoder, bound to its top level.
`include "assert_macros.svh"

module crad_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);

    logic report_cleared;
    logic axes_cleared;

    assign axes_cleared = m_axis_tdata[19:12] == crad_pkg::StickCenter &&
                          m_axis_tdata[27:20] == crad_pkg::StickCenter &&
                          m_axis_tdata[35:28] == crad_pkg::StickCenter &&
                          m_axis_tdata[43:36] == crad_pkg::StickCenter &&
                          m_axis_tdata[51:44] == crad_pkg::TrigRest &&
                          m_axis_tdata[59:52] == crad_pkg::TrigRest;
    assign report_cleared = axes_cleared && m_axis_tdata[11:0] == 12'd0;

    // A stalled result beat keeps its contents.
    `CRAD_ASSERT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result beat changed while stalled")

    // A protocol switch always comes with a cleared report.
    `CRAD_ASSERT(a_switch_clears, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser[1] |-> report_cleared, "switch without cleared report")

    // The shift-register protocol never carries analog data.
    `CRAD_ASSERT(a_sr_axes, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser[0] |-> axes_cleared, "analog data in shift-register mode")

    // No result beat is offered right after reset.
    `CRAD_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> !m_axis_tvalid, "result beat after reset")

endmodule

bind controller_report_autodetect_decoder_core crad_checker u_crad_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
